// ===== rtl/bmbp_pkg.sv =====
package bmbp_pkg;

   localparam int COUNT_W  = 24;
   localparam int PARENT_W = 11;
   localparam int BLEN_W   = 13;
   localparam int SYM_W    = 8;
   localparam int NUM_W    = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      FUNC_LOAD_QUERY  = 2'd0,
      FUNC_LOAD_TARGET = 2'd1,
      FUNC_COMPARE     = 2'd2,
      FUNC_NONE        = 2'd3
   } func_type;

   typedef struct packed {
      logic [PARENT_W-1:0] parent;
      logic [COUNT_W-1:0]  match_cnt;
      logic [COUNT_W-1:0]  mismatches;
   } tab_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic cnt_init;
      logic sym_read;
      logic sym_check;
      logic tab_read;
      logic tab_write;
      logic clr_write;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic start_empty;
      logic sym_equal;
      logic sym_end;
      logic walk_end;
      logic out_free;
      logic clr_end;
   } sts_type;

endpackage

// ===== rtl/block_match_best_parent.sv =====
// channel   direction  beat
// req_      in         one item: load query/target symbol or compare
// rsp_      out        one result per compare item
// csr_      in         block_length write, always ready
//
// Loads write the store as they are accepted. A compare reads and checks symbols, then the table;
// each block pair is checked symbol by symbol through the store read ports
// and stops at the first difference.
// After reset the parent table is swept clear entry by entry, req_ready low.
// A finished result waits in the output register; loads go on meanwhile,
// and the next compare waits for it only at its very end.
module block_match_best_parent
   import bmbp_pkg::*;
#(
   parameter int MAX_SEQ_LEN = 4096,
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic                req_last_symbol,
   input  logic [NUM_W-1:0]    req_query_number,
   input  logic [NUM_W-1:0]    req_target_number,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COUNT_W-1:0]  rsp_match_count,
   output logic [COUNT_W-1:0]  rsp_mismatch_count,
   output logic [PARENT_W-1:0] rsp_parent_number,
   output logic [COUNT_W-1:0]  rsp_parent_match_count,
   output logic [COUNT_W-1:0]  rsp_parent_mismatch_count,
   output logic                rsp_parent_changed,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [BLEN_W-1:0]   csr_block_length
);

   cmd_type  cmd;
   sts_type  sts;
   func_type func;

   assign func      = func_type'(req_func);
   assign csr_ready = 1'b1;

   bmbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmbp_datapath #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .req_func                  (func),
      .req_symbol                (req_symbol),
      .req_last_symbol           (req_last_symbol),
      .req_query_number          (req_query_number),
      .req_target_number         (req_target_number),
      .csr_valid                 (csr_valid && csr_ready),
      .csr_block_length          (csr_block_length),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_match_count           (rsp_match_count),
      .rsp_mismatch_count        (rsp_mismatch_count),
      .rsp_parent_number         (rsp_parent_number),
      .rsp_parent_match_count    (rsp_parent_match_count),
      .rsp_parent_mismatch_count (rsp_parent_mismatch_count),
      .rsp_parent_changed        (rsp_parent_changed),
      .cmd                       (cmd),
      .sts                       (sts)
   );

endmodule

// ===== rtl/bmbp_ctrl.sv =====
module bmbp_ctrl
   import bmbp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  func_type req_func,
   output logic     req_ready,
   input  sts_type  sts,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_CLR   = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_START = 7'b0000100,
      ST_RD    = 7'b0001000,
      ST_CMP   = 7'b0010000,
      ST_TRD   = 7'b0100000,
      ST_TUPD  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      pair_done;

   assign req_ready = (state_ff == ST_IDLE);
   assign pair_done = !sts.sym_equal || sts.sym_end;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.accept    = req_valid && req_ready;
      case (state_ff)
         ST_CLR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_func == FUNC_COMPARE) state_in = ST_START;
         end
         ST_START: begin
            cmd.cnt_init = 1'b1;
            state_in = sts.start_empty ? ST_TRD : ST_RD;
         end
         ST_RD: begin
            cmd.sym_read = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.sym_check = 1'b1;
            state_in = (pair_done && sts.walk_end) ? ST_TRD : ST_RD;
         end
         ST_TRD: begin
            cmd.tab_read = 1'b1;
            state_in = ST_TUPD;
         end
         ST_TUPD: begin
            if (sts.out_free) begin
               cmd.tab_write = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLR;
      else state_ff <= state_in;
   end

endmodule

// ===== rtl/bmbp_datapath.sv =====
module bmbp_datapath
   import bmbp_pkg::*;
#(
   parameter int MAX_SEQ_LEN = 4096,
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  func_type            req_func,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic                req_last_symbol,
   input  logic [NUM_W-1:0]    req_query_number,
   input  logic [NUM_W-1:0]    req_target_number,
   input  logic                csr_valid,
   input  logic [BLEN_W-1:0]   csr_block_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COUNT_W-1:0]  rsp_match_count,
   output logic [COUNT_W-1:0]  rsp_mismatch_count,
   output logic [PARENT_W-1:0] rsp_parent_number,
   output logic [COUNT_W-1:0]  rsp_parent_match_count,
   output logic [COUNT_W-1:0]  rsp_parent_mismatch_count,
   output logic                rsp_parent_changed,
   input  cmd_type             cmd,
   output sts_type             sts
);

   localparam int ADDR_W = $clog2(MAX_SEQ_LEN);
   localparam int LEN_W  = $clog2(MAX_SEQ_LEN + 1);
   localparam int SUM_W  = ((LEN_W > BLEN_W) ? LEN_W : BLEN_W) + 2;
   localparam int TAB_W  = $clog2(MAX_ENTRIES);

   logic [SYM_W-1:0] qmem [MAX_SEQ_LEN];
   logic [SYM_W-1:0] tmem [MAX_SEQ_LEN];
   tab_entry_type    tab  [MAX_ENTRIES];

   logic [BLEN_W-1:0] blen_ff;
   logic [LEN_W-1:0]  qfill_ff, tfill_ff, qlen_ff, tlen_ff;
   logic [LEN_W-1:0]  qo_ff, to_ff;
   logic [BLEN_W-1:0] k_ff;
   logic [COUNT_W-1:0] m_ff, mm_ff;
   logic [SYM_W-1:0]  qrd_ff, trd_ff;
   logic [NUM_W-1:0]  qn_ff, tn_ff;
   tab_entry_type     trd_ent_ff;
   logic [TAB_W-1:0]  clr_ff;
   logic              rsp_valid_ff;
   logic [COUNT_W-1:0]  rm_ff, rmm_ff, rpm_ff, rpmm_ff;
   logic [PARENT_W-1:0] rpn_ff;
   logic                rchg_ff;

   logic [BLEN_W-1:0] len;
   logic [SUM_W-1:0]  qo_next, to_next;
   logic [SUM_W-1:0]  qaddr, taddr;
   logic              load_q, load_t;
   logic              in_table, take, do_write;
   logic [TAB_W-1:0]  tidx;
   tab_entry_type     new_ent;

   assign len     = (blen_ff == '0) ? BLEN_W'(1) : blen_ff;
   assign qo_next = SUM_W'(qo_ff) + SUM_W'(len);
   assign to_next = SUM_W'(to_ff) + SUM_W'(len);
   assign qaddr   = SUM_W'(qo_ff) + SUM_W'(k_ff);
   assign taddr   = SUM_W'(to_ff) + SUM_W'(k_ff);
   assign load_q  = cmd.accept && req_func == FUNC_LOAD_QUERY;
   assign load_t  = cmd.accept && req_func == FUNC_LOAD_TARGET;

   assign sts.start_empty = !(SUM_W'(len) < SUM_W'(qlen_ff)) ||
                            !(SUM_W'(len) < SUM_W'(tlen_ff));
   assign sts.sym_equal   = (qrd_ff == trd_ff);
   assign sts.sym_end     = (k_ff == len - BLEN_W'(1));
   assign sts.walk_end    = !(to_next + SUM_W'(len) < SUM_W'(tlen_ff)) &&
                            !(qo_next + SUM_W'(len) < SUM_W'(qlen_ff));
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;
   assign sts.clr_end     = (clr_ff == TAB_W'(MAX_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) blen_ff <= BLEN_W'(1);
      else if (csr_valid) blen_ff <= csr_block_length;
   end

   // sequence stores and fill counts
   always_ff @(posedge clock) begin
      if (reset) begin
         qfill_ff <= '0;
         tfill_ff <= '0;
         qlen_ff  <= '0;
         tlen_ff  <= '0;
      end else begin
         if (load_q) begin
            if (qfill_ff < LEN_W'(MAX_SEQ_LEN)) begin
               qmem[qfill_ff[ADDR_W-1:0]] <= req_symbol;
               if (req_last_symbol) qlen_ff <= qfill_ff + LEN_W'(1);
               else qfill_ff <= qfill_ff + LEN_W'(1);
            end else if (req_last_symbol) begin
               qlen_ff <= qfill_ff;
            end
            if (req_last_symbol) qfill_ff <= '0;
         end
         if (load_t) begin
            if (tfill_ff < LEN_W'(MAX_SEQ_LEN)) begin
               tmem[tfill_ff[ADDR_W-1:0]] <= req_symbol;
               if (req_last_symbol) tlen_ff <= tfill_ff + LEN_W'(1);
               else tfill_ff <= tfill_ff + LEN_W'(1);
            end else if (req_last_symbol) begin
               tlen_ff <= tfill_ff;
            end
            if (req_last_symbol) tfill_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sym_read) begin
         qrd_ff <= qmem[qaddr[ADDR_W-1:0]];
         trd_ff <= tmem[taddr[ADDR_W-1:0]];
      end
   end

   // block walk
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         qn_ff <= req_query_number;
         tn_ff <= req_target_number;
      end
      if (cmd.cnt_init) begin
         qo_ff <= '0;
         to_ff <= '0;
         k_ff  <= '0;
         m_ff  <= '0;
         mm_ff <= '0;
      end else if (cmd.sym_check) begin
         if (!sts.sym_equal || sts.sym_end) begin
            k_ff <= '0;
            if (!sts.sym_equal) begin
               if (mm_ff != COUNT_MAX) mm_ff <= mm_ff + COUNT_W'(1);
            end else if (m_ff != COUNT_MAX) begin
               m_ff <= m_ff + COUNT_W'(1);
            end
            if (to_next + SUM_W'(len) < SUM_W'(tlen_ff)) begin
               to_ff <= to_next[LEN_W-1:0];
            end else begin
               to_ff <= '0;
               qo_ff <= qo_next[LEN_W-1:0];
            end
         end else begin
            k_ff <= k_ff + BLEN_W'(1);
         end
      end
   end

   // parent table
   assign in_table = {{(32-NUM_W){1'b0}}, tn_ff} < 32'(MAX_ENTRIES);
   assign tidx     = TAB_W'(tn_ff);
   assign take     = (trd_ent_ff.parent == '0) || (m_ff > trd_ent_ff.match_cnt) ||
                     (m_ff == trd_ent_ff.match_cnt && mm_ff < trd_ent_ff.mismatches);
   assign do_write = in_table && (qn_ff != tn_ff) && take;
   assign new_ent  = '{parent: PARENT_W'(qn_ff) + PARENT_W'(1),
                       match_cnt: m_ff, mismatches: mm_ff};

   always_ff @(posedge clock) begin
      if (cmd.clr_write) tab[clr_ff] <= '0;
      else if (cmd.tab_write && do_write) tab[tidx] <= new_ent;
      if (cmd.tab_read) trd_ent_ff <= tab[tidx];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_write) clr_ff <= clr_ff + TAB_W'(1);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.tab_write) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.tab_write) begin
         rm_ff   <= m_ff;
         rmm_ff  <= mm_ff;
         rchg_ff <= do_write;
         if (!in_table) begin
            rpn_ff  <= '0;
            rpm_ff  <= '0;
            rpmm_ff <= '0;
         end else if (do_write) begin
            rpn_ff  <= new_ent.parent;
            rpm_ff  <= new_ent.match_cnt;
            rpmm_ff <= new_ent.mismatches;
         end else begin
            rpn_ff  <= trd_ent_ff.parent;
            rpm_ff  <= trd_ent_ff.match_cnt;
            rpmm_ff <= trd_ent_ff.mismatches;
         end
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_match_count           = rm_ff;
   assign rsp_mismatch_count        = rmm_ff;
   assign rsp_parent_number         = rpn_ff;
   assign rsp_parent_match_count    = rpm_ff;
   assign rsp_parent_mismatch_count = rpmm_ff;
   assign rsp_parent_changed        = rchg_ff;

endmodule

// ===== rtl/bmbp_checker.sv =====
module bmbp_checker
   import bmbp_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COUNT_W-1:0]  rsp_match_count,
   input logic [COUNT_W-1:0]  rsp_mismatch_count,
   input logic [PARENT_W-1:0] rsp_parent_number,
   input logic [COUNT_W-1:0]  rsp_parent_match_count,
   input logic [COUNT_W-1:0]  rsp_parent_mismatch_count,
   input logic                rsp_parent_changed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count))
      else $error("rsp beat dropped or changed while stalled");

   a_changed_parent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parent_changed |-> rsp_parent_number != '0)
      else $error("parent replaced by none");

   a_changed_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parent_changed |->
         rsp_parent_match_count == rsp_match_count &&
         rsp_parent_mismatch_count == rsp_mismatch_count)
      else $error("new parent counts differ from this compare");

   a_no_parent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parent_number == '0 |->
         rsp_parent_match_count == '0 && rsp_parent_mismatch_count == '0)
      else $error("counts stored without a parent");

endmodule

bind block_match_best_parent bmbp_checker u_bmbp_checker (
   .clock                     (clock),
   .reset                     (reset),
   .rsp_valid                 (rsp_valid),
   .rsp_ready                 (rsp_ready),
   .rsp_match_count           (rsp_match_count),
   .rsp_mismatch_count        (rsp_mismatch_count),
   .rsp_parent_number         (rsp_parent_number),
   .rsp_parent_match_count    (rsp_parent_match_count),
   .rsp_parent_mismatch_count (rsp_parent_mismatch_count),
   .rsp_parent_changed        (rsp_parent_changed)
);
